>>> sv/cfc_pkg.sv
// Package for the cube face coordinate block: constants, face codes, stage types.
// No dependencies.
package cfc_pkg;
	localparam int VecW = 24;
	localparam int MagW = 24; // magnitude of a 24-bit value fits in 24 bits unsigned
	localparam int CoordW = 17;
	localparam int FaceW = 3;
	localparam int QuoW = 17; // quotient 0..MAX_COORD
	localparam logic [CoordW-1:0] MaxCoord = 17'd65536;
	localparam int ShW = 16; // log2(MaxCoord)

	typedef enum logic [FaceW-1:0] {
		FACE_RIGHT = 3'd0, FACE_LEFT = 3'd1, FACE_TOP = 3'd2,
		FACE_BOTTOM = 3'd3, FACE_FRONT = 3'd4, FACE_BACK = 3'd5
	} face_t;

	// Per-coordinate control going into the divider.
	typedef struct packed {
		logic          edge_val; // coordinate forced to edge
		logic          neg;      // result sign (edge sign or quotient sign)
		logic          center;   // coordinate is the centre
	} crd_ctl_t;
endpackage

>>> sv/cfc_div.sv
// Pipelined restoring divider: quotient = (num << 16) / den with num < den.
// Two quotient bits per stage, 8 stages. Uses cfc_pkg.
module cfc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [cfc_pkg::MagW-1:0]   num,
	input  logic [cfc_pkg::MagW-1:0]   den,
	input  cfc_pkg::crd_ctl_t          ctl_in,
	output logic                       out_valid,
	output logic [cfc_pkg::ShW-1:0]    quo,
	output cfc_pkg::crd_ctl_t          ctl_out
);
	localparam int Steps = cfc_pkg::ShW / 2;
	localparam int RW = cfc_pkg::MagW + 1;

	logic [Steps:0]              v_s1;
	logic [RW-1:0]               rem_s1 [Steps+1];
	logic [cfc_pkg::MagW-1:0]    den_s1 [Steps+1];
	logic [cfc_pkg::ShW-1:0]     q_s1   [Steps+1];
	cfc_pkg::crd_ctl_t           ctl_s1 [Steps+1];

	always_comb begin
		v_s1[0] = in_valid;
		rem_s1[0] = {1'b0, num};
		den_s1[0] = den;
		q_s1[0] = '0;
		ctl_s1[0] = ctl_in;
	end

	for (genvar i = 0; i < Steps; i++) begin : g_st
		logic [RW-1:0] r1, r2, t1, t2;
		logic b1, b2;
		always_comb begin
			t1 = {rem_s1[i][RW-2:0], 1'b0};
			b1 = t1 >= {1'b0, den_s1[i]};
			r1 = b1 ? t1 - {1'b0, den_s1[i]} : t1;
			t2 = {r1[RW-2:0], 1'b0};
			b2 = t2 >= {1'b0, den_s1[i]};
			r2 = b2 ? t2 - {1'b0, den_s1[i]} : t2;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s1[i+1] <= 1'b0;
			end else begin
				v_s1[i+1] <= v_s1[i];
			end
		end
		always_ff @(posedge clk) begin
			rem_s1[i+1] <= r2;
			den_s1[i+1] <= den_s1[i];
			q_s1[i+1] <= {q_s1[i][cfc_pkg::ShW-3:0], b1, b2};
			ctl_s1[i+1] <= ctl_s1[i];
		end
	end

	assign out_valid = v_s1[Steps];
	assign quo = q_s1[Steps];
	assign ctl_out = ctl_s1[Steps];
endmodule

>>> sv/cfc_front.sv
// Front end: face choice, major/minor pick, edge tests; one register stage.
// Uses cfc_pkg.
module cfc_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic                      action,
	input  logic [2:0]                face_in,
	input  logic signed [23:0]        vec_x,
	input  logic signed [23:0]        vec_y,
	input  logic signed [23:0]        vec_z,
	output logic                      out_valid,
	output logic [2:0]                face_s1,
	output logic [cfc_pkg::MagW-1:0]  num_s_s1,
	output logic [cfc_pkg::MagW-1:0]  num_t_s1,
	output logic [cfc_pkg::MagW-1:0]  den_s1,
	output cfc_pkg::crd_ctl_t         ctl_s_s1,
	output cfc_pkg::crd_ctl_t         ctl_t_s1
);
	logic [23:0] ax, ay, az, am, ms, mt;
	logic [2:0] face;
	logic signed [23:0] cs, ct;
	logic fs, ft, neg_a, a_zero, bad, behind, ctr;
	logic es, et;

	always_comb begin
		ax = vec_x[23] ? 24'(-vec_x) : vec_x;
		ay = vec_y[23] ? 24'(-vec_y) : vec_y;
		az = vec_z[23] ? 24'(-vec_z) : vec_z;
		face = face_in;
		if (!action) begin
			if (ax > ay && ax > az) begin
				face = (!vec_x[23] && vec_x != 0) ? cfc_pkg::FACE_RIGHT : cfc_pkg::FACE_LEFT;
			end else if (ay > az) begin
				face = (!vec_y[23] && vec_y != 0) ? cfc_pkg::FACE_TOP : cfc_pkg::FACE_BOTTOM;
			end else begin
				face = (!vec_z[23] && vec_z != 0) ? cfc_pkg::FACE_FRONT : cfc_pkg::FACE_BACK;
			end
		end
		bad = 1'b0;
		am = '0; neg_a = 1'b0; a_zero = 1'b1;
		cs = '0; ct = '0; fs = 1'b0; ft = 1'b0;
		// neg_a: a = -(component); a<0 means component sign matches negation
		case (face)
			cfc_pkg::FACE_RIGHT: begin
				am = ax; neg_a = vec_x[23]; a_zero = vec_x == 0;
				cs = vec_z; fs = 1'b1; ct = vec_y; ft = 1'b1;
			end
			cfc_pkg::FACE_LEFT: begin
				am = ax; neg_a = !vec_x[23] && vec_x != 0; a_zero = vec_x == 0;
				cs = vec_z; fs = 1'b0; ct = vec_y; ft = 1'b1;
			end
			cfc_pkg::FACE_TOP: begin
				am = ay; neg_a = vec_y[23]; a_zero = vec_y == 0;
				cs = vec_x; fs = 1'b0; ct = vec_z; ft = 1'b0;
			end
			cfc_pkg::FACE_BOTTOM: begin
				am = ay; neg_a = !vec_y[23] && vec_y != 0; a_zero = vec_y == 0;
				cs = vec_x; fs = 1'b0; ct = vec_z; ft = 1'b1;
			end
			cfc_pkg::FACE_FRONT: begin
				am = az; neg_a = vec_z[23]; a_zero = vec_z == 0;
				cs = vec_x; fs = 1'b0; ct = vec_y; ft = 1'b1;
			end
			cfc_pkg::FACE_BACK: begin
				am = az; neg_a = !vec_z[23] && vec_z != 0; a_zero = vec_z == 0;
				cs = vec_x; fs = 1'b1; ct = vec_y; ft = 1'b1;
			end
			default: bad = 1'b1;
		endcase
		ms = cs[23] ? 24'(-cs) : cs;
		mt = ct[23] ? 24'(-ct) : ct;
		ctr = bad || (!action && a_zero);
		behind = neg_a;
		es = behind || a_zero || am <= ms;
		et = behind || a_zero || am <= mt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		face_s1 <= face;
		den_s1 <= am;
		num_s_s1 <= es ? '0 : ms;
		num_t_s1 <= et ? '0 : mt;
		// edge: sign is (c>0 ? + : -) then flip; quotient: sign of c then flip
		ctl_s_s1.center <= ctr;
		ctl_s_s1.edge_val <= es;
		ctl_s_s1.neg <= es ? ((cs[23] || cs == 0) ^ fs) : (cs[23] ^ fs);
		ctl_t_s1.center <= ctr;
		ctl_t_s1.edge_val <= et;
		ctl_t_s1.neg <= et ? ((ct[23] || ct == 0) ^ ft) : (ct[23] ^ ft);
	end
endmodule

>>> sv/cfc_back.sv
// Back end: signs the quotient, applies edge/centre cases and bias; one stage.
// Uses cfc_pkg.
module cfc_back (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [2:0]                face,
	input  logic [cfc_pkg::ShW-1:0]   quo_s,
	input  logic [cfc_pkg::ShW-1:0]   quo_t,
	input  cfc_pkg::crd_ctl_t         ctl_s,
	input  cfc_pkg::crd_ctl_t         ctl_t,
	output logic                      out_valid,
	output logic [2:0]                face_out,
	output logic [cfc_pkg::CoordW-1:0] s_coord,
	output logic [cfc_pkg::CoordW-1:0] t_coord
);
	function automatic logic [cfc_pkg::CoordW-1:0] fin(
		input logic [cfc_pkg::ShW-1:0] q, input cfc_pkg::crd_ctl_t c);
		logic [cfc_pkg::CoordW:0] m, r;
		m = c.edge_val ? {1'b0, cfc_pkg::MaxCoord} : {2'b0, q};
		r = c.neg ? {1'b0, cfc_pkg::MaxCoord} - m : {1'b0, cfc_pkg::MaxCoord} + m;
		if (c.center) begin
			r = {1'b0, cfc_pkg::MaxCoord};
		end
		return r[cfc_pkg::CoordW:1];
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		face_out <= face;
		s_coord <= fin(quo_s, ctl_s);
		t_coord <= fin(quo_t, ctl_t);
	end
endmodule

>>> sv/cube_face_coordinates_top.sv
// Cube face coordinates: takes one word per cycle on start and returns it on done.
// Front stage, 8-stage divider pair, output stage. busy is always low; the receiver
// cannot stall and results show on done for one cycle.
// Asynchronous reset clears all valid bits; no word is in flight after reset.
// Top level of the cube face coordinate block. Uses cfc_pkg, cfc_front,
// cfc_div and cfc_back.
module cube_face_coordinates_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               action,
	input  logic [2:0]         face_in,
	input  logic signed [23:0] vec_x,
	input  logic signed [23:0] vec_y,
	input  logic signed [23:0] vec_z,
	output logic               done,
	output logic [2:0]         face_out,
	output logic [16:0]        s_coord,
	output logic [16:0]        t_coord
);
	localparam int Steps = cfc_pkg::ShW / 2;

	logic v1, vs, vt;
	logic [2:0] f1;
	logic [cfc_pkg::MagW-1:0] ns, nt, dn;
	cfc_pkg::crd_ctl_t cs1, ct1, cs2, ct2;
	logic [cfc_pkg::ShW-1:0] qs, qt;
	logic [2:0] face_s2 [Steps+1];

	assign busy = 1'b0;

	cfc_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(start), .action(action),
		.face_in(face_in), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z),
		.out_valid(v1), .face_s1(f1), .num_s_s1(ns), .num_t_s1(nt),
		.den_s1(dn), .ctl_s_s1(cs1), .ctl_t_s1(ct1)
	);

	cfc_div u_div_s (
		.clk(clk), .arst_n(arst_n), .in_valid(v1), .num(ns), .den(dn),
		.ctl_in(cs1), .out_valid(vs), .quo(qs), .ctl_out(cs2)
	);

	cfc_div u_div_t (
		.clk(clk), .arst_n(arst_n), .in_valid(v1), .num(nt), .den(dn),
		.ctl_in(ct1), .out_valid(vt), .quo(qt), .ctl_out(ct2)
	);

	// face code rides alongside the divider
	assign face_s2[0] = f1;
	for (genvar i = 0; i < Steps; i++) begin : g_face
		always_ff @(posedge clk) begin
			face_s2[i+1] <= face_s2[i];
		end
	end

	cfc_back u_back (
		.clk(clk), .arst_n(arst_n), .in_valid(vs & vt), .face(face_s2[Steps]),
		.quo_s(qs), .quo_t(qt), .ctl_s(cs2), .ctl_t(ct2),
		.out_valid(done), .face_out(face_out), .s_coord(s_coord), .t_coord(t_coord)
	);
endmodule

>>> sv/cfc_checker.sv
// Port-level checker for cube_face_coordinates_top, bound to the top level.
// Uses no package.
module cfc_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic        done,
	input logic [2:0]  face_out,
	input logic [16:0] s_coord,
	input logic [16:0] t_coord
);
	a_lat: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##10 done) else $error("word lost");
	a_noinv: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, 10)) else $error("spurious word");
	a_srng: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> s_coord <= 17'd65536 && t_coord <= 17'd65536) else $error("coord range");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy) else $error("busy");
endmodule

bind cube_face_coordinates_top cfc_checker u_cfc_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.face_out(face_out), .s_coord(s_coord), .t_coord(t_coord)
);

>>> test/tb.sv
// Testbench for cube_face_coordinates_top: directed table then random vectors,
// each result checked against a behavioral face/projection predictor or a typed table result.
// Depends on cfc_pkg and the RTL of the block.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint MaxC = 65536;
	localparam int Latency = 10;

	typedef struct {
		logic [2:0]  face;
		logic [16:0] s;
		logic [16:0] t;
	} coord_word_t;

	typedef struct {
		logic        action;
		logic [2:0]  face;
		logic [23:0] x;
		logic [23:0] y;
		logic [23:0] z;
		logic        known;
		coord_word_t res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic action;
	logic [2:0] face_in;
	logic signed [23:0] vec_x, vec_y, vec_z;
	logic done;
	logic [2:0] face_out;
	logic [16:0] s_coord, t_coord;

	coord_word_t pending_coords[$];
	int errors = 0;
	int send_idle = 8;
	dir_row_t rows[$];

	cube_face_coordinates_top DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .action(action),
		.face_in(face_in), .vec_x(vec_x), .vec_y(vec_y), .vec_z(vec_z), .done(done),
		.face_out(face_out), .s_coord(s_coord), .t_coord(t_coord)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL");
		$finish;
	end

	function automatic logic [16:0] face_coord(longint c, bit flip, longint a, bit forced);
		longint q;
		longint mc;
		mc = (c < 0) ? -c : c;
		if (forced || a <= mc || a <= 0) begin
			q = (c > 0) ? MaxC : -MaxC;
			if (flip) q = -q;
		end else begin
			q = ((flip ? -c : c) * MaxC) / a;
		end
		return 17'((q + MaxC) >>> 1);
	endfunction

	function automatic coord_word_t cube_project(logic act, logic [2:0] fin,
			logic [23:0] xv, logic [23:0] yv, logic [23:0] zv);
		coord_word_t r;
		longint x, y, z, ax, ay, az, a, cs, ct;
		bit fs, ft;
		logic [2:0] f;
		x = longint'($signed(xv));
		y = longint'($signed(yv));
		z = longint'($signed(zv));
		ax = x < 0 ? -x : x;
		ay = y < 0 ? -y : y;
		az = z < 0 ? -z : z;
		f = fin;
		if (act == 1'b0) begin
			if (ax > ay && ax > az) f = (x > 0) ? cfc_pkg::FACE_RIGHT : cfc_pkg::FACE_LEFT;
			else if (ay > az) f = (y > 0) ? cfc_pkg::FACE_TOP : cfc_pkg::FACE_BOTTOM;
			else f = (z > 0) ? cfc_pkg::FACE_FRONT : cfc_pkg::FACE_BACK;
		end
		a = 0; cs = 0; ct = 0; fs = 0; ft = 0;
		case (f)
			cfc_pkg::FACE_RIGHT: begin a = x; cs = z; fs = 1; ct = y; ft = 1; end
			cfc_pkg::FACE_LEFT: begin a = -x; cs = z; fs = 0; ct = y; ft = 1; end
			cfc_pkg::FACE_TOP: begin a = y; cs = x; fs = 0; ct = z; ft = 0; end
			cfc_pkg::FACE_BOTTOM: begin a = -y; cs = x; fs = 0; ct = z; ft = 1; end
			cfc_pkg::FACE_FRONT: begin a = z; cs = x; fs = 0; ct = y; ft = 1; end
			cfc_pkg::FACE_BACK: begin a = -z; cs = x; fs = 1; ct = y; ft = 1; end
			default: ;
		endcase
		r.face = f;
		if (f > cfc_pkg::FACE_BACK || (act == 1'b0 && a == 0)) begin
			r.s = 17'(MaxC >> 1);
			r.t = 17'(MaxC >> 1);
		end else begin
			r.s = face_coord(cs, fs, a, a < 0);
			r.t = face_coord(ct, ft, a, a < 0);
		end
		return r;
	endfunction

	// one word in, expectation queued on acceptance; start stays high between
	// back-to-back words and drops only while idling
	task automatic send_word(logic act, logic [2:0] f, logic [23:0] x, logic [23:0] y,
			logic [23:0] z, logic known, coord_word_t res);
		coord_word_t e;
		while (send_idle > 0 && $urandom_range(99) < send_idle) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		action <= act;
		face_in <= f;
		vec_x <= x;
		vec_y <= y;
		vec_z <= z;
		@(posedge clk);
		while (busy) @(posedge clk);
		e = cube_project(act, f, x, y, z);
		if (known && e != res) begin
			$error("table row: predictor face %0d s %0d t %0d, typed face %0d s %0d t %0d",
				e.face, e.s, e.t, res.face, res.s, res.t);
			errors++;
		end
		pending_coords.push_back(known ? res : e);
	endtask

	always @(posedge clk) begin
		coord_word_t e;
		if (arst_n && done) begin
			if (pending_coords.size() == 0) begin
				$error("unexpected word: face %0d s %0d t %0d", face_out, s_coord, t_coord);
				errors++;
			end else begin
				e = pending_coords.pop_front();
				if (face_out !== e.face) begin
					$error("face_out: expected %0d, got %0d", e.face, face_out);
					errors++;
				end
				if (s_coord !== e.s) begin
					$error("s_coord: expected %0d, got %0d", e.s, s_coord);
					errors++;
				end
				if (t_coord !== e.t) begin
					$error("t_coord: expected %0d, got %0d", e.t, t_coord);
					errors++;
				end
			end
		end
	end

	function automatic logic [23:0] rand_comp();
		case ($urandom_range(9))
			0: return 24'h800000;
			1: return 24'h7FFFFF;
			2: return 24'h800001;
			3: return 24'(int'($urandom_range(8)) - 4);
			4: return 24'($urandom_range(255));
			5: return -24'($urandom_range(255));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic dir_row_t mk(logic act, logic [2:0] f, int x, int y, int z,
			logic known, int rf, int rs, int rt);
		dir_row_t r;
		r.action = act; r.face = f;
		r.x = 24'(x); r.y = 24'(y); r.z = 24'(z);
		r.known = known;
		r.res.face = 3'(rf); r.res.s = 17'(rs); r.res.t = 17'(rt);
		return r;
	endfunction

	initial begin
		logic [23:0] x, y, z;
		logic [2:0] f;
		start = 1'b0; action = 1'b0; face_in = '0;
		vec_x = '0; vec_y = '0; vec_z = '0;
		arst_n = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero vector: centre on back for select, corners for project; invalid faces: centre
		rows.push_back(mk(0, 0, 0, 0, 0, 1, cfc_pkg::FACE_BACK, 32768, 32768));
		rows.push_back(mk(1, cfc_pkg::FACE_RIGHT, 0, 0, 0, 1, cfc_pkg::FACE_RIGHT,
			65536, 65536));
		rows.push_back(mk(1, cfc_pkg::FACE_TOP, 0, 0, 0, 1, cfc_pkg::FACE_TOP, 0, 0));
		rows.push_back(mk(1, 6, 5, 5, 5, 1, 6, 32768, 32768));
		rows.push_back(mk(1, 7, -5, 1, 2, 1, 7, 32768, 32768));
		// axis-aligned: face centre
		rows.push_back(mk(0, 0, 8388607, 0, 0, 1, cfc_pkg::FACE_RIGHT, 32768, 32768));
		rows.push_back(mk(0, 0, -8388608, 0, 0, 1, cfc_pkg::FACE_LEFT, 32768, 32768));
		rows.push_back(mk(0, 0, 0, 8388607, 0, 1, cfc_pkg::FACE_TOP, 32768, 32768));
		rows.push_back(mk(0, 0, 0, -8388608, 0, 1, cfc_pkg::FACE_BOTTOM, 32768, 32768));
		rows.push_back(mk(0, 0, 0, 0, 8388607, 1, cfc_pkg::FACE_FRONT, 32768, 32768));
		rows.push_back(mk(0, 0, 0, 0, -8388608, 1, cfc_pkg::FACE_BACK, 32768, 32768));
		// ties
		rows.push_back(mk(0, 0, 5, 5, 5, 0, 0, 0, 0));
		rows.push_back(mk(0, 0, 5, -5, 3, 0, 0, 0, 0));
		rows.push_back(mk(0, 0, -7, 2, -7, 0, 0, 0, 0));
		rows.push_back(mk(0, 0, -8388608, -8388608, -8388608, 0, 0, 0, 0));
		rows.push_back(mk(0, 0, 8388607, -8388608, 8388607, 0, 0, 0, 0));
		// behind, edges, interior for each given face
		for (int i = 0; i < 6; i++)
			rows.push_back(mk(1, 3'(i), -8388608, 8388607, -3, 0, 0, 0, 0));
		rows.push_back(mk(1, cfc_pkg::FACE_FRONT, 100, -50, 100, 0, 0, 0, 0));
		rows.push_back(mk(1, cfc_pkg::FACE_BACK, 3, 2, -1000, 0, 0, 0, 0));
		foreach (rows[i])
			send_word(rows[i].action, rows[i].face, rows[i].x, rows[i].y, rows[i].z,
				rows[i].known, rows[i].res);

		for (int ph = 0; ph < 3; ph++) begin
			send_idle = (ph == 0) ? 8 : (ph == 1) ? 71 : 0;
			for (int n = 0; n < 550; n++) begin
				x = rand_comp(); y = rand_comp(); z = rand_comp();
				f = $urandom_range(99) < 90 ? 3'($urandom_range(5)) : 3'($urandom_range(7));
				send_word(1'($urandom), f, x, y, z, 1'b0, '{default: '0});
				if (n == 275) begin
					// drain the pipe before going on
					start <= 1'b0;
					while (pending_coords.size() != 0) @(posedge clk);
				end
			end
		end
		start <= 1'b0;

		fork
			while (pending_coords.size() != 0) @(posedge clk);
			repeat (2000) @(posedge clk);
		join_any
		disable fork;
		repeat (Latency + 5) @(posedge clk);
		if (errors == 0 && pending_coords.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

>>> files.f
sv/cfc_pkg.sv
sv/cfc_div.sv
sv/cfc_front.sv
sv/cfc_back.sv
sv/cube_face_coordinates_top.sv
sv/cfc_checker.sv
test/tb.sv
